[rtl/lphs_pkg.sv]
// ----------------------------------------------------------------------------
// lphs_pkg: shared types and constants for the linear-probe hash set
// Item structs, status and op codes, hash multipliers and register defaults.
// ----------------------------------------------------------------------------
package lphs_pkg;

	// Table geometry and register defaults
	localparam int unsigned TABLE_SLOTS_DEF = 1024;
	localparam int unsigned SLOT_W          = 10;
	localparam int unsigned COUNT_W         = 10;
	localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = 10'd614;

	// splitmix64 finalizer multipliers
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	// Op codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	// Status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_MISS     = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_ZERO     = 3'd4;

	typedef struct packed {
		logic        op;
		logic [63:0] key;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] entry_count;
	} out_item_t;

endpackage

[rtl/linear_probe_hash_set.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_set: open-addressing set of nonzero 64-bit keys
// splitmix64 home slot, linear wrapping probes, zero word marks empty.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | in_valid / in_ready    | in_item  (op, key)
//  output   | out_valid / out_ready  | out_item (status, slot, entry_count)
//  config   | cfg_we (no wait)       | cfg_wdata -> max_entries
//
//  One item at a time. Zero key or full refusal: accept, then load result.
//  Other items: accept, hashing on one shared 32x32 multiplier
//  (three partial products per 64-bit multiply), then a remainder by
//  reciprocal multiply on the same unit when TABLE_SLOTS is not a power of two,
//  then per probe a table read and a compare, then the output load.
//  After reset a clearing pass zeroes the table; no input is taken meanwhile.
//  A stalled result holds the block; the next item is taken once it is loaded.
//
module linear_probe_hash_set #(
	parameter int unsigned TABLE_SLOTS = lphs_pkg::TABLE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lphs_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lphs_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [lphs_pkg::COUNT_W-1:0]  cfg_wdata
);
	import lphs_pkg::*;

	localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
	localparam bit          IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [31:0]      SLOTS_W32 = 32'(TABLE_SLOTS);
	// floor(2^32 / TABLE_SLOTS): quotient estimate is low by at most one
	localparam logic [31:0]      MOD_INV = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_MUL, S_FIX, S_MOD, S_RD, S_CHK, S_HOLD
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	out_item_t           out_q;
	out_item_t           res_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  max_q;
	logic [IDX_W-1:0]    clr_q;
	logic                op_q;
	logic [63:0]         key_q;
	logic [63:0]         v_q;
	logic [63:0]         acc_q;
	logic [63:0]         prod_q;
	logic [1:0]          step_q;
	logic                pass_q;
	logic [1:0]          chunk_q;
	logic [31:0]         y_q;
	logic [IDX_W-1:0]    rem_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    home_q;
	logic [IDX_W-1:0]    probe_q;

	// Table memory
	logic [63:0]      mem [TABLE_SLOTS];
	logic [63:0]      rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [63:0]      mem_wd;

	// Shared multiplier operands
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_c;

	logic [63:0]      hval;
	logic [31:0]      mod_r;
	logic [IDX_W-1:0] mod_nx;
	logic [IDX_W-1:0] idx_nx;
	logic             slot_empty;
	logic             slot_hit;
	logic             probe_last;
	logic             is_full;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Partial product select: lo*lo, lo*hi, hi*lo; remainder: y*inv, q*slots
	assign mul_c = pass_q ? MIX_C2 : MIX_C1;
	always_comb begin
		if (state_q == S_MOD) begin
			case (step_q)
				2'd1: begin
					mul_a = y_q;
					mul_b = MOD_INV;
				end
				default: begin
					mul_a = prod_q[63:32];
					mul_b = SLOTS_W32;
				end
			endcase
		end else begin
			case (step_q)
				2'd0: begin
					mul_a = v_q[31:0];
					mul_b = mul_c[31:0];
				end
				2'd1: begin
					mul_a = v_q[31:0];
					mul_b = mul_c[63:32];
				end
				default: begin
					mul_a = v_q[63:32];
					mul_b = mul_c[31:0];
				end
			endcase
		end
	end

	// Final hash and one 16-bit remainder digit: y - q*slots, one correction
	assign hval   = acc_q ^ (acc_q >> 31);
	assign mod_r  = y_q - prod_q[31:0];
	assign mod_nx = (mod_r >= SLOTS_W32) ? IDX_W'(mod_r - SLOTS_W32) : IDX_W'(mod_r);

	// Probe compare
	assign slot_empty = (rd_q == 64'd0);
	assign slot_hit   = (rd_q == key_q);
	assign probe_last = (probe_q == LAST_IDX);
	assign idx_nx     = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign is_full    = (count_q >= max_q) ||
		({22'd0, count_q} >= SLOTS_W32);

	// Memory write port: clearing pass or insert into an empty slot
	assign mem_we = (state_q == S_CLEAR) ||
		((state_q == S_CHK) && (op_q == OP_INSERT) && slot_empty);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign mem_wd = (state_q == S_CLEAR) ? 64'd0 : key_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			max_q       <= MAX_ENTRIES_RST;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != S_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= in_item.op;
						key_q  <= in_item.key;
						v_q    <= in_item.key ^ (in_item.key >> 30);
						step_q <= 2'd0;
						pass_q <= 1'b0;
						probe_q <= '0;
						if (in_item.key == 64'd0) begin
							res_q   <= '{status: ST_ZERO, slot: '0, entry_count: count_q};
							state_q <= S_HOLD;
						end else if (in_item.op == OP_INSERT && is_full) begin
							res_q   <= '{status: ST_FULL, slot: '0, entry_count: count_q};
							state_q <= S_HOLD;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				// Low 64 bits of v * C from three 32x32 partial products
				S_MUL: begin
					prod_q <= mul_a * mul_b;
					step_q <= step_q + 2'd1;
					case (step_q)
						2'd0: ;
						2'd1: acc_q <= prod_q;
						default: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					endcase
					if (step_q == 2'd3) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					step_q <= 2'd0;
					if (!pass_q) begin
						v_q     <= acc_q ^ (acc_q >> 27);
						pass_q  <= 1'b1;
						state_q <= S_MUL;
					end else if (IS_POW2) begin
						idx_q   <= hval[IDX_W-1:0];
						home_q  <= hval[IDX_W-1:0];
						state_q <= S_RD;
					end else begin
						v_q     <= hval;
						rem_q   <= '0;
						chunk_q <= '0;
						state_q <= S_MOD;
					end
				end
				// Hash modulo table size, 16 bits at a time from the top
				S_MOD: begin
					step_q <= step_q + 2'd1;
					case (step_q)
						2'd0: begin
							y_q <= {16'(rem_q), v_q[63:48]};
							v_q <= {v_q[47:0], 16'd0};
						end
						2'd1, 2'd2: begin
							prod_q <= mul_a * mul_b;
						end
						default: begin
							rem_q   <= mod_nx;
							chunk_q <= chunk_q + 2'd1;
							if (chunk_q == 2'd3) begin
								idx_q   <= mod_nx;
								home_q  <= mod_nx;
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_HOLD;
					if (op_q == OP_INSERT) begin
						if (slot_empty) begin
							count_q <= count_q + 1'b1;
							res_q   <= '{status: ST_INSERTED, slot: SLOT_W'(idx_q),
								entry_count: count_q + 1'b1};
						end else if (probe_last) begin
							res_q   <= '{status: ST_FULL, slot: '0, entry_count: count_q};
						end else begin
							idx_q   <= idx_nx;
							probe_q <= probe_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (slot_empty) begin
							res_q <= '{status: ST_MISS, slot: SLOT_W'(idx_q), entry_count: count_q};
						end else if (slot_hit) begin
							res_q <= '{status: ST_FOUND, slot: SLOT_W'(idx_q), entry_count: count_q};
						end else if (probe_last) begin
							res_q <= '{status: ST_MISS, slot: SLOT_W'(home_q), entry_count: count_q};
						end else begin
							idx_q   <= idx_nx;
							probe_q <= probe_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// Count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == COUNT_W'($past(count_q) + 1'b1)))
		else $error("entry count jumped");

	// Count changes only on an insert into an empty slot
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_CHK && $past(op_q) == OP_INSERT))
		else $error("entry count changed outside an insert");

	// Zero key goes straight to the result stage
	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.key == 64'd0) |=>
		(state_q == S_HOLD && res_q.status == ST_ZERO))
		else $error("zero key not rejected");

	// Table writes only in the clearing pass or at an insert check
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || (state_q == S_CHK && op_q == OP_INSERT)))
		else $error("stray table write");

	// A new result is loaded only when the output register is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD && out_valid_q && !out_ready) |=> (state_q == S_HOLD))
		else $error("result overwrote a pending item");
`endif

endmodule
